// File: design/flash_unary_counter_assert.svh
// Assertion macros shared by the flash unary counter RTL.
`ifndef FLASH_UNARY_COUNTER_ASSERT_SVH
`define FLASH_UNARY_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FUC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flash_unary_counter: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FUC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flash_unary_counter: next-cycle check failed");

`endif

// File: design/fuc_pkg.sv
// Types, constants and helper functions of the flash unary counter.
`default_nettype none

package fuc_pkg;

  localparam int unsigned WORD_BITS = 32;

  typedef struct packed {
    logic        op;
    logic [31:0] amount;
  } fuc_in_t;

  typedef struct packed {
    logic [63:0] value;
    logic        rebased;
  } fuc_out_t;

  localparam logic OP_READ = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
    logic        cin;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        cout;
  } alu_res_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic erase;
  } area_ctl_t;

  // Trailing zeros of a nonzero word, halving the window each step.
  function automatic logic [4:0] tz32(input logic [31:0] w);
    logic [31:0] v;
    logic [4:0]  n;
    v = w;
    n = '0;
    if (v[15:0] == 16'h0) begin
      n[4] = 1'b1;
      v = v >> 16;
    end
    if (v[7:0] == 8'h0) begin
      n[3] = 1'b1;
      v = v >> 8;
    end
    if (v[3:0] == 4'h0) begin
      n[2] = 1'b1;
      v = v >> 4;
    end
    if (v[1:0] == 2'h0) begin
      n[1] = 1'b1;
      v = v >> 2;
    end
    if (v[0] == 1'b0) begin
      n[0] = 1'b1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: design/fuc_alu.sv
// Shared 32-bit add unit with carry in and registered sum and carry out.
`default_nettype none

module fuc_alu
  import fuc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire alu_req_t req_i,
  output alu_res_t      res_o
);

  logic [32:0] sum;
  alu_res_t    res_q;

  assign sum = 33'(req_i.a) + 33'(req_i.b) + 33'(req_i.cin);

  // Result holds until the next issued request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (req_i.en) begin
      res_q <= '{sum: sum[31:0], cout: sum[32]};
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// File: design/fuc_area.sv
// Bit-area word memory with a fill count standing in for the erased state.
`default_nettype none

module fuc_area
  import fuc_pkg::*;
#(
  parameter  int unsigned AREA_WORDS = 8,
  localparam int unsigned IDX_W      = (AREA_WORDS > 1) ? $clog2(AREA_WORDS) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire area_ctl_t            ctl_i,
  input  wire logic [IDX_W-1:0]     rd_addr_i,
  input  wire logic [IDX_W-1:0]     wr_addr_i,
  input  wire logic [WORD_BITS-1:0] wr_data_i,
  output logic      [WORD_BITS-1:0] rd_word_o
);

  localparam int unsigned CNT_W = $clog2(AREA_WORDS + 1);

  logic [WORD_BITS-1:0] mem [AREA_WORDS];
  logic [WORD_BITS-1:0] rd_q;
  logic                 rd_vld_q;
  logic [CNT_W-1:0]     fill_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // Words at or above the fill count were never written since the last erase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.rd_en) begin
        rd_vld_q <= (CNT_W'(rd_addr_i) < fill_q);
      end
      if (ctl_i.erase) begin
        fill_q <= '0;
      end else if (ctl_i.wr_en && (CNT_W'(wr_addr_i) >= fill_q)) begin
        fill_q <= CNT_W'(wr_addr_i) + CNT_W'(1);
      end
    end
  end

  assign rd_word_o = rd_vld_q ? rd_q : '1;

endmodule

`default_nettype wire

// File: design/flash_unary_counter.sv
// Top level of the flash unary counter: sequencer, base register and result stage.
`default_nettype none

// Wear-friendly counter kept as a 64-bit base plus an area of AREA_WORDS erased
// (all ones) 32-bit words, of which a contiguous run from bit 0 is cleared; the
// run length is the offset and a result beat carries base plus offset after the
// operation. Every command first binary searches the area for the first nonzero
// word (each probe a read through the single registered memory read port, at
// most ceil(log2(AREA_WORDS+1)) probes, then a check that the window has closed)
// and counts its trailing zeros.
// A read or an add of zero then forms the value; an add that stays below the
// capacity AREA_WORDS*32 walks the memory write port one word per cycle over the
// words it clears; one that reaches the capacity rebases the base and erases the
// area at once by dropping the fill count, so no clearing pass is needed after
// reset or rebase. The 64-bit additions go through one shared 32-bit add unit in
// low and high halves. One item is in flight at a time; the finished beat waits
// in an output register, so the next command is taken while it is stalled.
module flash_unary_counter
  import fuc_pkg::*;
#(
  parameter int unsigned AREA_WORDS = 8
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire fuc_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output fuc_out_t      out_data_o
);

`include "flash_unary_counter_assert.svh"

  localparam int unsigned IDX_W    = (AREA_WORDS > 1) ? $clog2(AREA_WORDS) : 1;
  localparam int unsigned CNT_W    = $clog2(AREA_WORDS + 1);
  localparam int unsigned OFFS_W   = CNT_W + 5;
  localparam logic [31:0] CAPACITY = 32'(AREA_WORDS * WORD_BITS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SRCH_RD = 4'd1;
  localparam logic [3:0] S_SRCH_EV = 4'd2;
  localparam logic [3:0] S_TZ_RD   = 4'd3;
  localparam logic [3:0] S_TZ_EV   = 4'd4;
  localparam logic [3:0] S_SUM     = 4'd5;
  localparam logic [3:0] S_CHK     = 4'd6;
  localparam logic [3:0] S_CLR     = 4'd7;
  localparam logic [3:0] S_REB_LO  = 4'd8;
  localparam logic [3:0] S_REB_HI  = 4'd9;
  localparam logic [3:0] S_REB_WR  = 4'd10;
  localparam logic [3:0] S_VAL_LO  = 4'd11;
  localparam logic [3:0] S_VAL_HI  = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  logic [3:0]        state_q, state_d;

  // Command held for the whole operation.
  logic              op_q;
  logic [31:0]       amount_q;
  logic              add_go;

  // Search window and probe index.
  logic [CNT_W-1:0]  low_q, high_q, mid_q;
  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  mid;

  logic [OFFS_W-1:0] offset_q;
  logic [OFFS_W-1:0] end_q;
  logic [32:0]       sum_q;
  logic [IDX_W-1:0]  w_q, last_q;
  logic [OFFS_W-1:0] end_m1;

  logic [63:0]       base_q;
  logic [31:0]       lo_q;
  logic              rebased_q;

  logic              out_valid_q;
  fuc_out_t          out_data_q;
  logic              out_load;

  alu_req_t          alu_req;
  alu_res_t          alu_res;
  area_ctl_t         area_ctl;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [31:0]       wr_data;
  logic [31:0]       rd_word;
  logic              fits;

  fuc_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .res_o  (alu_res)
  );

  fuc_area #(
    .AREA_WORDS (AREA_WORDS)
  ) u_area (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (area_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_word_o (rd_word)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign add_go     = (op_q == OP_ADD) && (amount_q != 32'h0);
  assign mid_sum    = (CNT_W + 1)'(low_q) + (CNT_W + 1)'(high_q);
  assign mid        = mid_sum[CNT_W:1];
  assign fits       = !alu_res.cout && (alu_res.sum < CAPACITY);
  assign end_m1     = OFFS_W'(alu_res.sum) - OFFS_W'(1);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Word being programmed: fully cleared below the last word, partly or fully in it.
  always_comb begin
    if (w_q != last_q) begin
      wr_data = '0;
    end else if (end_q[4:0] == 5'd0) begin
      wr_data = '0;
    end else begin
      wr_data = 32'hFFFF_FFFF << end_q[4:0];
    end
  end

  assign wr_addr = w_q;

  always_comb begin
    state_d  = state_q;
    alu_req  = '0;
    area_ctl = '0;
    rd_addr  = mid[IDX_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (low_q < high_q) begin
          area_ctl.rd_en = 1'b1;
          state_d        = S_SRCH_EV;
        end else begin
          state_d = S_TZ_RD;
        end
      end
      S_SRCH_EV: begin
        state_d = S_SRCH_RD;
      end
      S_TZ_RD: begin
        rd_addr = low_q[IDX_W-1:0];
        if (low_q < CNT_W'(AREA_WORDS)) begin
          area_ctl.rd_en = 1'b1;
          state_d        = S_TZ_EV;
        end else begin
          state_d = add_go ? S_SUM : S_VAL_LO;
        end
      end
      S_TZ_EV: begin
        state_d = add_go ? S_SUM : S_VAL_LO;
      end
      S_SUM: begin
        alu_req = '{en: 1'b1, a: 32'(offset_q), b: amount_q, cin: 1'b0};
        state_d = S_CHK;
      end
      S_CHK: begin
        state_d = fits ? S_CLR : S_REB_LO;
      end
      S_CLR: begin
        area_ctl.wr_en = 1'b1;
        if (w_q == last_q) begin
          state_d = S_VAL_LO;
        end
      end
      S_REB_LO: begin
        alu_req = '{en: 1'b1, a: base_q[31:0], b: sum_q[31:0], cin: 1'b0};
        state_d = S_REB_HI;
      end
      S_REB_HI: begin
        alu_req = '{en: 1'b1, a: base_q[63:32], b: 32'(sum_q[32]), cin: alu_res.cout};
        state_d = S_REB_WR;
      end
      S_REB_WR: begin
        area_ctl.erase = 1'b1;
        state_d        = S_VAL_LO;
      end
      S_VAL_LO: begin
        alu_req = '{en: 1'b1, a: base_q[31:0], b: 32'(offset_q), cin: 1'b0};
        state_d = S_VAL_HI;
      end
      S_VAL_HI: begin
        alu_req = '{en: 1'b1, a: base_q[63:32], b: 32'h0, cin: alu_res.cout};
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer and the counter base.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      base_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_REB_WR) begin
        base_q <= {alu_res.sum, lo_q};
      end
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_q      <= in_data_i.op;
          amount_q  <= in_data_i.amount;
          low_q     <= '0;
          high_q    <= CNT_W'(AREA_WORDS);
          rebased_q <= 1'b0;
        end
      end
      S_SRCH_RD: begin
        mid_q <= mid;
      end
      S_SRCH_EV: begin
        // Advance past a fully cleared word, else narrow onto it.
        if (rd_word == 32'h0) begin
          low_q <= mid_q + CNT_W'(1);
        end else begin
          high_q <= mid_q;
        end
      end
      S_TZ_RD: begin
        offset_q <= {low_q, 5'd0};
      end
      S_TZ_EV: begin
        offset_q <= {low_q, tz32(rd_word)};
      end
      S_CHK: begin
        sum_q  <= {alu_res.cout, alu_res.sum};
        end_q  <= OFFS_W'(alu_res.sum);
        w_q    <= IDX_W'(offset_q[OFFS_W-1:5]);
        last_q <= IDX_W'(end_m1[OFFS_W-1:5]);
      end
      S_CLR: begin
        if (w_q == last_q) begin
          offset_q <= end_q;
        end else begin
          w_q <= w_q + IDX_W'(1);
        end
      end
      S_REB_HI: begin
        lo_q <= alu_res.sum;
      end
      S_REB_WR: begin
        offset_q  <= '0;
        rebased_q <= 1'b1;
      end
      S_VAL_HI: begin
        lo_q <= alu_res.sum;
      end
      default: begin
      end
    endcase
  end

  // Output stage: hold the beat until the far side takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= '{value: {alu_res.sum, lo_q}, rebased: rebased_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `FUC_ASSERT_NXT(a_accept_starts_search, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == S_SRCH_RD)
  `FUC_ASSERT_IMP(a_walk_in_range, clk_i, rst_ni, state_q == S_CLR, w_q <= last_q)
  `FUC_ASSERT_NXT(a_beat_only_from_done, clk_i, rst_ni, state_q != S_DONE && !out_valid_q, !out_valid_q)
  `FUC_ASSERT_IMP(a_offset_bounded, clk_i, rst_ni, state_q == S_SUM, offset_q <= OFFS_W'(CAPACITY))

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench of the flash unary counter: a scoreboard class and handshake drivers.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fuc_pkg::*;

  // Size the area as the default build does; the capacity is the bit count.
  localparam int unsigned AREA_WORDS      = 8;
  localparam int unsigned CAPACITY        = AREA_WORDS * WORD_BITS;
  localparam int unsigned RANDOM_ITEMS    = 1950;
  // Bound the run at a generous multiple of the slowest correct case: the
  // longest item per command, plus sender gaps, receiver stalls and the hold-off.
  localparam int unsigned CYCLE_LIMIT     = 600000;
  // Wait this long after the last expected beat for stray results.
  localparam int unsigned TAIL_CYCLES     = 60;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned MAX_REPORTS     = 30;

  // Receiver stall patterns, switched at random intervals.
  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  // Scoreboard: keeps its own copy of the base and the bit area, works out
  // the result of each accepted command and checks returned beats in order.
  class count_scoreboard;
    logic [63:0] base;
    logic [31:0] area [AREA_WORDS];
    fuc_out_t    expected_counts [$];
    int unsigned errors;
    int unsigned results;
    int unsigned reads;
    int unsigned zero_adds;
    int unsigned adds;
    int unsigned rebases;

    function new();
      base = '0;
      foreach (area[w]) area[w] = '1;
      errors    = 0;
      results   = 0;
      reads     = 0;
      zero_adds = 0;
      adds      = 0;
      rebases   = 0;
    endfunction

    // Length of the cleared run from bit 0 of word 0.
    function int unsigned cleared_bits();
      int unsigned run;
      int unsigned w;
      int unsigned b;
      run = 0;
      w   = 0;
      while (w < AREA_WORDS && area[w] == '0) begin
        run += WORD_BITS;
        w++;
      end
      if (w < AREA_WORDS) begin
        b = 0;
        while (area[w][b] == 1'b0) begin
          run++;
          b++;
        end
      end
      return run;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $error("%s", msg);
    endfunction

    // Apply one accepted command and queue the beat it must produce.
    function void note_command(fuc_in_t cmd);
      int unsigned     run;
      longint unsigned reach;
      fuc_out_t        want;
      run          = cleared_bits();
      want.rebased = 1'b0;
      if (cmd.op == OP_READ) begin
        reads++;
      end else if (cmd.amount == '0) begin
        zero_adds++;
      end else begin
        adds++;
        reach = longint'(run) + longint'(cmd.amount);
        if (reach < CAPACITY) begin
          for (int unsigned i = run; i < reach; i++)
            area[i / WORD_BITS][i % WORD_BITS] = 1'b0;
        end else begin
          base = base + reach;
          foreach (area[w]) area[w] = '1;
          want.rebased = 1'b1;
          rebases++;
        end
        run = cleared_bits();
      end
      want.value = base + 64'(run);
      expected_counts.push_back(want);
    endfunction

    function void check_result(fuc_out_t got);
      fuc_out_t want;
      results++;
      if (expected_counts.size() == 0) begin
        flag($sformatf("result beat with nothing expected: value %0h rebased %0b",
                       got.value, got.rebased));
      end else begin
        want = expected_counts.pop_front();
        if (got.value !== want.value)
          flag($sformatf("value mismatch: expected %0h, actual %0h", want.value, got.value));
        if (got.rebased !== want.rebased)
          flag($sformatf("rebased mismatch: expected %0b, actual %0b",
                         want.rebased, got.rebased));
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  fuc_in_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  fuc_out_t    out_data_o;

  int unsigned     cycles        = 0;
  int unsigned     hold_off_asked = 0;
  count_scoreboard board         = new();

  flash_unary_counter #(
    .AREA_WORDS(AREA_WORDS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Watchdog: stop a hung run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d beats outstanding",
               cycles, board.expected_counts.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sample both handshakes at the rising edge. Note the command first: the
  // queue is in order, so a beat leaving in the same cycle still pops the
  // older expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_command(in_data_i);
      if (out_valid_o && !out_stall_i) board.check_result(out_data_o);
    end
  end

  // Receiver: stall on a pattern of its own, and serve long hold-offs on
  // request so that the output register and the input side back up.
  initial begin : receiver
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned served;
    mode      = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    served    = 0;
    forever begin
      @(negedge clk_i);
      if (served != hold_off_asked) begin
        served    = hold_off_asked;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(40, 300);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  // Offer one command beat and hold it until the block takes it. Valid stays
  // high on return so that a burst runs back to back.
  task automatic offer(input logic op, input logic [31:0] amount);
    fuc_in_t cmd;
    cmd.op     = op;
    cmd.amount = amount;
    in_data_i  <= cmd;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid for a gap set by n; a zero gap leaves valid alone.
  task automatic pause(input int unsigned n);
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Hold the sender until every expected beat has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (board.expected_counts.size() != 0) @(negedge clk_i);
  endtask

  // One random command. Most adds are short, so runs cross word boundaries
  // step by step; some land exactly on the capacity or one short of it.
  task automatic offer_random();
    int unsigned pick;
    int unsigned run;
    pick = $urandom_range(0, 99);
    run  = board.cleared_bits();
    if (pick < 10)      offer(OP_READ, $urandom());
    else if (pick < 18) offer(OP_ADD, 32'd0);
    else if (pick < 58) offer(OP_ADD, $urandom_range(1, 40));
    else if (pick < 73) offer(OP_ADD, $urandom_range(1, 300));
    else if (pick < 81) offer(OP_ADD, $urandom());
    else if (pick < 88) offer(OP_ADD, 32'(CAPACITY - run));
    else if (pick < 94) offer(OP_ADD, 32'(CAPACITY - 1 - run));
    else                offer(OP_ADD, $urandom_range(1, 8));
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned burst;
    bit          held;
    bit          drained;
    sent    = 0;
    held    = 1'b0;
    drained = 1'b0;

    // Reset once, released on a falling edge.
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed part: reads, adds of zero, word boundaries, the last bit of
    // the area, exact capacity with and without cleared bits, and overflow.
    offer(OP_READ, 32'd0);
    offer(OP_ADD,  32'd0);
    offer(OP_ADD,  32'd1);
    offer(OP_ADD,  32'd31);
    offer(OP_READ, 32'hFFFF_FFFF);
    offer(OP_ADD,  32'hFFFF_FFFF);
    pause(5);
    offer(OP_ADD,  32'd255);
    offer(OP_READ, 32'd0);
    offer(OP_ADD,  32'd0);
    offer(OP_ADD,  32'd1);
    offer(OP_ADD,  32'd256);
    offer(OP_ADD,  32'd100);
    offer(OP_ADD,  32'd100);
    offer(OP_ADD,  32'd55);
    offer(OP_ADD,  32'd2);
    offer(OP_ADD,  32'd32);
    offer(OP_ADD,  32'd224);
    offer(OP_ADD,  32'h8000_0000);
    offer(OP_ADD,  32'h7FFF_FFFF);
    offer(OP_READ, 32'h5555_AAAA);
    drain();

    // Random part in bursts with random gaps.
    while (sent < RANDOM_ITEMS) begin
      // Once, stall the receiver for a long stretch and keep offering.
      if (!held && sent >= 400) begin
        held = 1'b1;
        hold_off_asked++;
        repeat (16) offer_random();
        sent += 16;
      end
      // Pause the sender until everything is back, once for sure and now
      // and then after that.
      if ((!drained && sent >= 1000) || $urandom_range(0, 39) == 0) begin
        drained = 1'b1;
        drain();
      end
      burst = $urandom_range(1, 12);
      repeat (burst) offer_random();
      sent += burst;
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 20));
    end

    // Let the last beats out, then watch a while for strays.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d commands: %0d reads, %0d adds of zero, %0d nonzero adds",
             board.reads + board.zero_adds + board.adds,
             board.reads, board.zero_adds, board.adds);
    $display("Checked %0d result beats, %0d rebases, final count %0h",
             board.results, board.rebases, board.base + 64'(board.cleared_bits()));
    if (board.errors == 0 && board.expected_counts.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
